// ===== sv/tird_pkg.sv =====
// Shared types and codes for the tape image record deframer.
// Self-contained; used by the core and by its port checker.
`default_nettype none

package tird_pkg;

    // Default widths of the internal state
    localparam int DEF_LENGTH_BITS      = 24;
    localparam int DEF_FILE_NUMBER_BITS = 16;
    localparam int DEF_COUNT_BITS       = 32;

    // Field types of one result
    typedef logic [1:0]  t_kind;
    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_file_num;
    typedef logic [23:0] t_rec_len;
    typedef logic [1:0]  t_reason;
    typedef logic [31:0] t_count;

    // Event kinds
    localparam t_kind EV_DATA   = 2'd0;
    localparam t_kind EV_RECORD = 2'd1;
    localparam t_kind EV_CLOSE  = 2'd2;
    localparam t_kind EV_STOP   = 2'd3;

    // Stop reasons
    localparam t_reason STOP_INPUT_END = 2'd0;
    localparam t_reason STOP_EOM       = 2'd1;
    localparam t_reason STOP_DBL_MARK  = 2'd2;
    localparam t_reason STOP_TRUNCATED = 2'd3;

    // Special header words
    localparam logic [31:0] WORD_EOM  = 32'hFFFF_FFFF;
    localparam logic [31:0] WORD_MARK = 32'h0000_0000;

    // One input request
    typedef struct packed {
        t_byte tape_byte;
        logic  end_of_input;
    } t_in;

    // One result request
    typedef struct packed {
        t_kind     event_kind;
        t_byte     data_byte;
        t_file_num file_index;
        t_rec_len  record_length;
        logic      record_error;
        t_reason   stop_reason;
        logic      file_closes_at_stop;
        t_count    records_seen;
        t_count    errors_seen;
    } t_out;

endpackage

`default_nettype wire

// ===== sv/tape_image_record_deframer_core.sv =====
// Tape image record deframer core: byte parser, counters, output register and skid stage.
// Depends on tird_pkg.
`default_nettype none

// Takes one tape image byte per clock while o_in_ready is high, and produces at most one
// event per byte: data bytes with their record context, record complete, file closed by
// a tape mark, and a single stop event carrying the final record and error counts. The
// result of an accepted byte is registered in the output register, or in the skid buffer.
// The parser state updates in a single register stage, and an output register plus a
// one-entry skid buffer let input keep flowing while a result waits for i_out_ready.
// After the stop event the core keeps accepting bytes and discards them until reset.
module tape_image_record_deframer_core #(
    parameter int LENGTH_BITS      = tird_pkg::DEF_LENGTH_BITS,
    parameter int FILE_NUMBER_BITS = tird_pkg::DEF_FILE_NUMBER_BITS,
    parameter int COUNT_BITS       = tird_pkg::DEF_COUNT_BITS
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire tird_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output tird_pkg::t_out      o_out_data
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_DATA,
        PH_PAD,
        PH_TRAILER
    } t_phase;

    // Parser state
    t_phase                  r_phase, n_phase;
    logic [1:0]              r_cnt, n_cnt;
    logic [23:0]             r_hdr, n_hdr;
    logic [LENGTH_BITS-1:0]  r_left, n_left;
    logic [LENGTH_BITS-1:0]  r_len, n_len;
    logic                    r_err, n_err;
    logic [1:0]              r_marks, n_marks;
    logic                    r_has, n_has;
    logic [FILE_NUMBER_BITS-1:0] r_file, n_file;
    logic [COUNT_BITS-1:0]   r_rec, n_rec;
    logic [COUNT_BITS-1:0]   r_errs, n_errs;
    logic                    r_halted, n_halted;

    // Output register and skid stage
    logic                    r_out_valid, n_out_valid;
    tird_pkg::t_out          r_out, n_out;
    logic                    r_skid_valid, n_skid_valid;
    tird_pkg::t_out          r_skid, n_skid;
    logic                    r_in_ready;

    logic                    in_fire;
    logic                    res_valid;
    tird_pkg::t_out          res;
    logic [31:0]             word;

    assign in_fire     = i_in_valid && r_in_ready;
    assign word        = {i_in_data.tape_byte, r_hdr};
    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Parser: next state and the result of the accepted byte
    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_hdr    = r_hdr;
        n_left   = r_left;
        n_len    = r_len;
        n_err    = r_err;
        n_marks  = r_marks;
        n_has    = r_has;
        n_file   = r_file;
        n_rec    = r_rec;
        n_errs   = r_errs;
        n_halted = r_halted;

        res_valid               = 1'b0;
        res.event_kind          = tird_pkg::EV_DATA;
        res.data_byte           = '0;
        res.file_index          = tird_pkg::t_file_num'(r_file);
        res.record_length       = '0;
        res.record_error        = 1'b0;
        res.stop_reason         = tird_pkg::STOP_INPUT_END;
        res.file_closes_at_stop = 1'b0;

        if (in_fire && !r_halted) begin
            if (i_in_data.end_of_input) begin
                // input ends: clean at a header, truncated elsewhere
                res_valid               = 1'b1;
                n_halted                = 1'b1;
                res.event_kind          = tird_pkg::EV_STOP;
                res.file_closes_at_stop = r_has;
                if (r_phase != PH_HEADER) begin
                    res.stop_reason   = tird_pkg::STOP_TRUNCATED;
                    res.record_length = tird_pkg::t_rec_len'(r_len);
                    res.record_error  = r_err;
                end
            end else begin
                unique case (r_phase)
                    PH_DATA: begin
                        n_left            = r_left - LENGTH_BITS'(1);
                        if (r_left <= LENGTH_BITS'(1)) begin
                            n_left  = '0;
                            n_phase = r_len[0] ? PH_PAD : PH_TRAILER;
                        end
                        res_valid         = 1'b1;
                        res.data_byte     = i_in_data.tape_byte;
                        res.record_length = tird_pkg::t_rec_len'(r_len);
                        res.record_error  = r_err;
                    end
                    PH_PAD: begin
                        n_phase = PH_TRAILER;
                        n_cnt   = '0;
                    end
                    PH_TRAILER: begin
                        n_cnt = r_cnt + 2'd1;
                        if (r_cnt == 2'd3) begin
                            // trailer skipped: record complete
                            if (r_rec != '1) begin
                                n_rec = r_rec + COUNT_BITS'(1);
                            end
                            if (r_err && (r_errs != '1)) begin
                                n_errs = r_errs + COUNT_BITS'(1);
                            end
                            n_has             = 1'b1;
                            n_phase           = PH_HEADER;
                            res_valid         = 1'b1;
                            res.event_kind    = tird_pkg::EV_RECORD;
                            res.record_length = tird_pkg::t_rec_len'(r_len);
                            res.record_error  = r_err;
                        end
                    end
                    default: begin
                        // header word, little-endian
                        n_cnt = r_cnt + 2'd1;
                        if (r_cnt != 2'd3) begin
                            n_hdr[8*r_cnt +: 8] = i_in_data.tape_byte;
                        end else if (word == tird_pkg::WORD_EOM) begin
                            res_valid               = 1'b1;
                            n_halted                = 1'b1;
                            res.event_kind          = tird_pkg::EV_STOP;
                            res.stop_reason         = tird_pkg::STOP_EOM;
                            res.file_closes_at_stop = r_has;
                        end else if (word == tird_pkg::WORD_MARK) begin
                            if (r_marks < 2'd2) begin
                                n_marks = r_marks + 2'd1;
                            end
                            if (r_has) begin
                                // close the file; number shown is the closed one
                                n_has          = 1'b0;
                                res_valid      = 1'b1;
                                res.event_kind = tird_pkg::EV_CLOSE;
                                if (r_file != '1) begin
                                    n_file = r_file + FILE_NUMBER_BITS'(1);
                                end
                            end else if (n_marks >= 2'd2) begin
                                res_valid               = 1'b1;
                                n_halted                = 1'b1;
                                res.event_kind          = tird_pkg::EV_STOP;
                                res.stop_reason         = tird_pkg::STOP_DBL_MARK;
                                res.file_closes_at_stop = r_has;
                            end
                        end else begin
                            // record header
                            n_marks = '0;
                            n_err   = word[31];
                            n_len   = word[LENGTH_BITS-1:0];
                            n_left  = word[LENGTH_BITS-1:0];
                            n_cnt   = '0;
                            n_phase = (word[LENGTH_BITS-1:0] != '0) ? PH_DATA : PH_TRAILER;
                        end
                    end
                endcase
            end
        end

        // totals after this byte
        res.records_seen = tird_pkg::t_count'(n_rec);
        res.errors_seen  = tird_pkg::t_count'(n_errs);
    end

    // Output register with a one-entry skid buffer
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || i_out_ready) begin
            n_out_valid  = r_skid_valid || res_valid;
            n_out        = r_skid_valid ? r_skid : res;
            n_skid_valid = 1'b0;
        end else if (res_valid) begin
            n_skid_valid = 1'b1;
            n_skid       = res;
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_cnt        <= '0;
            r_left       <= '0;
            r_len        <= '0;
            r_err        <= 1'b0;
            r_marks      <= '0;
            r_has        <= 1'b0;
            r_file       <= FILE_NUMBER_BITS'(1);
            r_rec        <= '0;
            r_errs       <= '0;
            r_halted     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
            r_in_ready   <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_cnt        <= n_cnt;
            r_left       <= n_left;
            r_len        <= n_len;
            r_err        <= n_err;
            r_marks      <= n_marks;
            r_has        <= n_has;
            r_file       <= n_file;
            r_rec        <= n_rec;
            r_errs       <= n_errs;
            r_halted     <= n_halted;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
            r_in_ready   <= !n_skid_valid;
        end
        // payload registers
        r_hdr  <= n_hdr;
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

`default_nettype wire

// ===== sv/tird_checker.sv =====
// Port-level checker for the tape image record deframer core, with its bind.
// Depends on tird_pkg and tape_image_record_deframer_core.
`default_nettype none

module tird_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_out_valid,
    input wire logic           i_out_ready,
    input wire tird_pkg::t_out o_out_data
);

    logic r_stop_done;

    // remember that the stop event has been delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_done <= 1'b0;
        end else if (o_out_valid && i_out_ready
                     && (o_out_data.event_kind == tird_pkg::EV_STOP)) begin
            r_stop_done <= 1'b1;
        end
    end

    // a stalled result stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result request dropped while stalled");

    // a stalled result keeps its payload
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // nothing follows a delivered stop
    a_quiet_after_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stop_done |-> !o_out_valid)
        else $error("result after stop event");

    // stop-only fields are zero on other events
    a_stop_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.event_kind != tird_pkg::EV_STOP)
        |-> (o_out_data.stop_reason == tird_pkg::STOP_INPUT_END)
            && !o_out_data.file_closes_at_stop)
        else $error("stop fields set on a non-stop event");

endmodule

bind tape_image_record_deframer_core tird_checker u_tird_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
